// File: rtl/clnw_pkg.sv
// Package for the character LCD nibble writer: item types, register and
// function codes, queue entry type and configuration bundle.
// Depends on nothing.
package clnw_pkg;

   localparam int MAX_LINES     = 4;
   localparam int MAX_COLS      = 20;
   localparam int QUEUE_DEPTH   = 2;
   localparam int CSR_ADDR_W    = 5;
   localparam int CSR_DATA_W    = 32;

   localparam logic [7:0] NEWLINE_CODE  = 8'h0A;
   localparam logic [7:0] CMD_CLEAR     = 8'h01;
   localparam logic [7:0] CMD_SET_DDRAM = 8'h80;

   localparam logic [2:0] FUNC_RAW_CMD  = 3'd0;
   localparam logic [2:0] FUNC_RAW_DATA = 3'd1;
   localparam logic [2:0] FUNC_TEXT     = 3'd2;
   localparam logic [2:0] FUNC_CURSOR   = 3'd3;
   localparam logic [2:0] FUNC_CLEAR    = 3'd4;

   localparam logic [1:0] WAIT_HOLD     = 2'd0;
   localparam logic [1:0] WAIT_CMD      = 2'd1;
   localparam logic [1:0] WAIT_CHAR     = 2'd2;

   localparam logic [2:0] REG_LINE_COUNT  = 3'd0;
   localparam logic [2:0] REG_LINE_WIDTH  = 3'd1;
   localparam logic [2:0] REG_LINE0_START = 3'd2;
   localparam logic [2:0] REG_LINE1_START = 3'd3;
   localparam logic [2:0] REG_LINE2_START = 3'd4;
   localparam logic [2:0] REG_LINE3_START = 3'd5;

   typedef struct packed {
      logic [2:0] func;
      logic [7:0] byte_value;
      logic [7:0] target_line;
      logic [7:0] target_col;
   } req_type;

   typedef struct packed {
      logic       register_select;
      logic [3:0] nibble;
      logic [1:0] wait_class;
      logic       rejected;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [2:0]      line_count;
      logic [4:0]      line_width;
      logic [3:0][6:0] line_start;
   } cfg_type;

   typedef struct packed {
      logic       reject;
      logic       two_bytes;
      logic       rs0;
      logic [7:0] byte0;
      logic [7:0] byte1;
   } job_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

endpackage

// File: rtl/char_lcd_nibble_writer_unit.sv
// Top level of the character LCD nibble writer: registers, front, job queue
// and back. Depends on clnw_pkg, clnw_csr, clnw_front, clnw_queue, clnw_back.
//
//   channel  direction  handshake                 payload
//   req      in         req_valid / req_stall     clnw_pkg::req_type
//   rsp      out        rsp_valid / rsp_stall     clnw_pkg::rsp_type
//   csr      in/out     psel penable pwrite pready paddr pwdata prdata
//
// One nibble item leaves per cycle from the back output register while
// rsp_stall is low: a byte item gives 2 nibbles, a wrapping text character 4,
// a refused set cursor 1. An item is queued before its first nibble is loaded.
// Reset is synchronous and clears cursor, queue and output valid; registers
// return to their defaults. req_stall rises only while the queue is full.
module char_lcd_nibble_writer_unit #(
   parameter int QUEUE_DEPTH = clnw_pkg::QUEUE_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  clnw_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output clnw_pkg::rsp_type               rsp_data,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [clnw_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [clnw_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [clnw_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);

   clnw_pkg::cfg_type          cfg;
   clnw_pkg::job_type          push_job;
   clnw_pkg::job_type          head_job;
   clnw_pkg::queue_status_type q_status;
   logic                       push;
   logic                       pop;

   clnw_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   clnw_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .cfg        (cfg),
      .queue_full (q_status.full),
      .push       (push),
      .job        (push_job)
   );

   clnw_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_job),
      .pop       (pop),
      .head      (head_job),
      .status    (q_status)
   );

   clnw_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head_job),
      .status    (q_status),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   a_reset_clears_output: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("output valid after reset");

   a_high_nibble_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.rejected && rsp_data.wait_class == clnw_pkg::WAIT_HOLD)
      |-> !rsp_data.last)
      else $error("item ended on a high nibble");

   a_idle_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_data.func <= clnw_pkg::FUNC_CLEAR &&
       q_status.empty && !rsp_valid) |=> ##1 rsp_valid)
      else $error("first nibble late from idle");

   a_queue_status: assert property (@(posedge clock) disable iff (reset)
      push |=> !q_status.empty)
      else $error("queue empty after push");

endmodule

// File: rtl/clnw_csr.sv
// Configuration registers of the LCD nibble writer behind an APB-style port.
// Depends on clnw_pkg.
module clnw_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [clnw_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [clnw_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [clnw_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready,
   output clnw_pkg::cfg_type               cfg
);

   clnw_pkg::cfg_type cfg_ff;
   clnw_pkg::cfg_type cfg_in;
   logic [2:0]        reg_index;
   logic              wr_en;

   assign pready    = 1'b1;
   assign reg_index = paddr[4:2];
   assign wr_en     = psel && penable && pwrite && pready;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_index)
            clnw_pkg::REG_LINE_COUNT:  cfg_in.line_count    = pwdata[2:0];
            clnw_pkg::REG_LINE_WIDTH:  cfg_in.line_width    = pwdata[4:0];
            clnw_pkg::REG_LINE0_START: cfg_in.line_start[0] = pwdata[6:0];
            clnw_pkg::REG_LINE1_START: cfg_in.line_start[1] = pwdata[6:0];
            clnw_pkg::REG_LINE2_START: cfg_in.line_start[2] = pwdata[6:0];
            clnw_pkg::REG_LINE3_START: cfg_in.line_start[3] = pwdata[6:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         clnw_pkg::REG_LINE_COUNT:  prdata = {29'd0, cfg_ff.line_count};
         clnw_pkg::REG_LINE_WIDTH:  prdata = {27'd0, cfg_ff.line_width};
         clnw_pkg::REG_LINE0_START: prdata = {25'd0, cfg_ff.line_start[0]};
         clnw_pkg::REG_LINE1_START: prdata = {25'd0, cfg_ff.line_start[1]};
         clnw_pkg::REG_LINE2_START: prdata = {25'd0, cfg_ff.line_start[2]};
         clnw_pkg::REG_LINE3_START: prdata = {25'd0, cfg_ff.line_start[3]};
         default:                   prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.line_count    <= 3'd2;
         cfg_ff.line_width    <= 5'd16;
         cfg_ff.line_start[0] <= 7'd0;
         cfg_ff.line_start[1] <= 7'd64;
         cfg_ff.line_start[2] <= 7'd20;
         cfg_ff.line_start[3] <= 7'd84;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: rtl/clnw_front.sv
// Front end of the LCD nibble writer: accepts items, tracks the cursor and
// turns each known item into a job of up to two bytes. Depends on clnw_pkg.
module clnw_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  clnw_pkg::req_type    req_data,
   input  clnw_pkg::cfg_type    cfg,
   input  logic                 queue_full,
   output logic                 push,
   output clnw_pkg::job_type    job
);

   logic [1:0] cursor_line_ff;
   logic [1:0] cursor_line_in;
   logic [4:0] cursor_col_ff;
   logic [4:0] cursor_col_in;
   logic       accept;
   logic       known_func;
   logic [2:0] line_cnt;
   logic [2:0] wrap_rem;
   logic [1:0] next_line;
   logic [6:0] next_start;
   logic [6:0] cursor_addr;
   logic       cursor_bad;

   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      priority if (cfg.line_count == 3'd0) begin
         line_cnt = 3'd1;
      end else if (cfg.line_count > 3'(clnw_pkg::MAX_LINES)) begin
         line_cnt = 3'(clnw_pkg::MAX_LINES);
      end else begin
         line_cnt = cfg.line_count;
      end
      wrap_rem = {1'b0, cursor_line_ff} + 3'd1;
      for (int i = 0; i < clnw_pkg::MAX_LINES; i++) begin
         if (wrap_rem >= line_cnt) begin
            wrap_rem = wrap_rem - line_cnt;
         end
      end
      next_line  = wrap_rem[1:0];
      next_start = cfg.line_start[next_line];
   end

   assign cursor_bad  = (req_data.target_line > 8'(clnw_pkg::MAX_LINES - 1)) ||
                        (req_data.target_col > 8'(clnw_pkg::MAX_COLS - 1));
   assign cursor_addr = cfg.line_start[req_data.target_line[1:0]] +
                        req_data.target_col[6:0];

   always_comb begin
      job            = '0;
      known_func     = 1'b1;
      cursor_line_in = cursor_line_ff;
      cursor_col_in  = cursor_col_ff;
      unique case (req_data.func)
         clnw_pkg::FUNC_RAW_CMD: begin
            job.byte0 = req_data.byte_value;
         end
         clnw_pkg::FUNC_RAW_DATA: begin
            job.rs0   = 1'b1;
            job.byte0 = req_data.byte_value;
         end
         clnw_pkg::FUNC_TEXT: begin
            if (req_data.byte_value == clnw_pkg::NEWLINE_CODE) begin
               job.byte0      = clnw_pkg::CMD_SET_DDRAM | {1'b0, next_start};
               cursor_line_in = next_line;
               cursor_col_in  = 5'd0;
            end else begin
               job.rs0   = 1'b1;
               job.byte0 = req_data.byte_value;
               if (({1'b0, cursor_col_ff} + 6'd1) >= {1'b0, cfg.line_width}) begin
                  job.two_bytes  = 1'b1;
                  job.byte1      = clnw_pkg::CMD_SET_DDRAM | {1'b0, next_start};
                  cursor_line_in = next_line;
                  cursor_col_in  = 5'd0;
               end else begin
                  cursor_col_in = cursor_col_ff + 5'd1;
               end
            end
         end
         clnw_pkg::FUNC_CURSOR: begin
            if (cursor_bad) begin
               job.reject = 1'b1;
            end else begin
               job.byte0      = clnw_pkg::CMD_SET_DDRAM | {1'b0, cursor_addr};
               cursor_line_in = req_data.target_line[1:0];
               cursor_col_in  = req_data.target_col[4:0];
            end
         end
         clnw_pkg::FUNC_CLEAR: begin
            job.byte0      = clnw_pkg::CMD_CLEAR;
            cursor_line_in = 2'd0;
            cursor_col_in  = 5'd0;
         end
         default: begin
            known_func = 1'b0;
         end
      endcase
   end

   assign push = accept && known_func;

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_line_ff <= 2'd0;
         cursor_col_ff  <= 5'd0;
      end else if (accept) begin
         cursor_line_ff <= cursor_line_in;
         cursor_col_ff  <= cursor_col_in;
      end
   end

endmodule

// File: rtl/clnw_queue.sv
// Short queue of byte jobs between front and back of the LCD nibble writer.
// Depends on clnw_pkg.
module clnw_queue #(
   parameter int DEPTH = clnw_pkg::QUEUE_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  clnw_pkg::job_type          push_data,
   input  logic                       pop,
   output clnw_pkg::job_type          head,
   output clnw_pkg::queue_status_type status
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   clnw_pkg::job_type entry_ff [DEPTH];
   logic [AW-1:0]     wr_ptr_ff;
   logic [AW-1:0]     wr_ptr_in;
   logic [AW-1:0]     rd_ptr_ff;
   logic [AW-1:0]     rd_ptr_in;
   logic [CW-1:0]     count_ff;
   logic [CW-1:0]     count_in;
   logic              do_push;
   logic              do_pop;

   assign status.empty = (count_ff == CW'(0));
   assign status.full  = (count_ff == CW'(DEPTH));
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head         = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/clnw_back.sv
// Back end of the LCD nibble writer: splits queued jobs into nibble items
// in the output register, one per unstalled cycle. Depends on clnw_pkg.
module clnw_back (
   input  logic                       clock,
   input  logic                       reset,
   input  clnw_pkg::job_type          head,
   input  clnw_pkg::queue_status_type status,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output clnw_pkg::rsp_type          rsp_data
);

   logic [1:0]        idx_ff;
   logic [1:0]        idx_in;
   logic [1:0]        last_idx;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   clnw_pkg::rsp_type rsp_data_ff;
   clnw_pkg::rsp_type rsp_data_in;
   logic              out_free;
   logic              load;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign load     = out_free && !status.empty;

   always_comb begin
      priority if (head.reject) begin
         last_idx = 2'd0;
      end else if (head.two_bytes) begin
         last_idx = 2'd3;
      end else begin
         last_idx = 2'd1;
      end
   end

   always_comb begin
      rsp_data_in      = '0;
      rsp_data_in.last = (idx_ff == last_idx);
      unique case (idx_ff)
         2'd0: begin
            rsp_data_in.register_select = head.rs0 && !head.reject;
            rsp_data_in.nibble          = head.reject ? 4'd0 : head.byte0[7:4];
            rsp_data_in.wait_class      = clnw_pkg::WAIT_HOLD;
            rsp_data_in.rejected        = head.reject;
         end
         2'd1: begin
            rsp_data_in.register_select = head.rs0;
            rsp_data_in.nibble          = head.byte0[3:0];
            rsp_data_in.wait_class      = head.rs0 ? clnw_pkg::WAIT_CHAR : clnw_pkg::WAIT_CMD;
         end
         2'd2: begin
            rsp_data_in.nibble     = head.byte1[7:4];
            rsp_data_in.wait_class = clnw_pkg::WAIT_HOLD;
         end
         2'd3: begin
            rsp_data_in.nibble     = head.byte1[3:0];
            rsp_data_in.wait_class = clnw_pkg::WAIT_CMD;
         end
         default: ;
      endcase
   end

   always_comb begin
      pop          = 1'b0;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = load;
      end
      if (load) begin
         if (idx_ff == last_idx) begin
            pop    = 1'b1;
            idx_in = 2'd0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
